@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the lexer RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ttl_pkg.sv @@
// ---------------------------------------------------------------------------
// ttl_pkg
// Types, constants and byte classification for the text token lexer
// ---------------------------------------------------------------------------
package ttl_pkg;

   localparam int POS_BITS     = 16;
   localparam int OFF_BITS     = 16;
   localparam int RES_DEPTH    = 4;
   localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
   localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);

   typedef logic [POS_BITS-1:0]     pos_type;
   typedef logic [OFF_BITS-1:0]     off_type;
   typedef logic [RES_PTR_BITS-1:0] ptr_type;
   typedef logic [RES_CNT_BITS-1:0] cnt_type;

   localparam logic [2:0] KIND_STRING  = 3'd0;
   localparam logic [2:0] KIND_INT     = 3'd1;
   localparam logic [2:0] KIND_FLOAT   = 3'd2;
   localparam logic [2:0] KIND_SYMBOL  = 3'd3;
   localparam logic [2:0] KIND_IDENT   = 3'd4;
   localparam logic [2:0] KIND_UNKNOWN = 3'd5;

   localparam logic [7:0] CHR_QUOTE      = 8'h22;
   localparam logic [7:0] CHR_MINUS      = 8'h2D;
   localparam logic [7:0] CHR_DOT        = 8'h2E;
   localparam logic [7:0] CHR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHR_BACKSPACE  = 8'h08;

   typedef struct packed {
      logic [2:0] kind;
      off_type    start_off;
      off_type    end_off;
      logic [7:0] sym;
      logic       unterm;
      logic       run_last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } scan_out_type;

   function automatic pos_type pos_inc(input pos_type p);
      return (p == '1) ? p : p + pos_type'(1);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A) ||
             (c == CHR_BACKSPACE);
   endfunction

   function automatic logic is_symbol(input logic [7:0] c);
      logic hit;
      hit = 1'b0;
      case (c) inside
         ".", ",", ":", ";", "#", "(", ")", "{", "}", "[", "]", "+", "-",
         "*", "/", "%", "&", "|", "^", "<", ">", "!", "$", "=", "?": hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic is_ident_part(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CHR_UNDERSCORE);
   endfunction

   function automatic logic is_number_part(input logic [7:0] c);
      logic [7:0] lc;
      lc = ((c >= "A") && (c <= "Z")) ? (c | 8'h20) : c;
      return is_digit(lc) || ((lc >= "a") && (lc <= "f")) || (lc == "x") ||
             (lc == "o") || (lc == "u") || (lc == "l") || (lc == CHR_MINUS) ||
             (lc == CHR_UNDERSCORE) || (lc == CHR_DOT);
   endfunction

   function automatic token_type make_tok(input logic [2:0] kind, input pos_type start_p,
                                          input pos_type end_p, input logic [7:0] sym,
                                          input logic unterm);
      token_type t;
      t.kind      = kind;
      t.start_off = off_type'(start_p);
      t.end_off   = off_type'(end_p);
      t.sym       = sym;
      t.unterm    = unterm;
      t.run_last  = 1'b0;
      return t;
   endfunction

endpackage

@@ rtl/core/ttl_scan.sv @@
// ---------------------------------------------------------------------------
// ttl_scan
// Lexer state and per-byte token decision, up to two tokens per item
// ---------------------------------------------------------------------------
module ttl_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [7:0]            char_byte,
   input  logic                  last_char,
   output ttl_pkg::scan_out_type scan_out
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_STRING,
      MODE_NUMBER,
      MODE_IDENT,
      MODE_MINUS
   } mode_type;

   mode_type         mode_ff, mode_in, mode_mid;
   ttl_pkg::pos_type pos_ff, pos_in;
   ttl_pkg::pos_type start_ff, start_in, start_mid;
   logic             dot_ff, dot_in, dot_mid;

   ttl_pkg::pos_type   p, p1;
   logic               do_fresh;
   logic [1:0]         n;
   ttl_pkg::token_type tok [2];

   always_comb begin
      p         = pos_ff;
      p1        = ttl_pkg::pos_inc(pos_ff);
      mode_mid  = mode_ff;
      start_mid = start_ff;
      dot_mid   = dot_ff;
      do_fresh  = 1'b0;
      n         = 2'd0;
      tok[0]    = '0;
      tok[1]    = '0;

      unique case (mode_ff)
         MODE_STRING: begin
            if (char_byte == ttl_pkg::CHR_QUOTE) begin
               tok[n[0]] = ttl_pkg::make_tok(ttl_pkg::KIND_STRING, start_ff, p1, 8'd0, 1'b0);
               n         = n + 2'd1;
               mode_mid  = MODE_IDLE;
            end
         end
         MODE_NUMBER: begin
            if (ttl_pkg::is_number_part(char_byte)) begin
               if (char_byte == ttl_pkg::CHR_DOT) begin
                  dot_mid = 1'b1;
               end
            end else begin
               tok[n[0]] = ttl_pkg::make_tok(dot_ff ? ttl_pkg::KIND_FLOAT : ttl_pkg::KIND_INT,
                                             start_ff, p, 8'd0, 1'b0);
               n         = n + 2'd1;
               do_fresh  = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (!ttl_pkg::is_ident_part(char_byte)) begin
               tok[n[0]] = ttl_pkg::make_tok(ttl_pkg::KIND_IDENT, start_ff, p, 8'd0, 1'b0);
               n         = n + 2'd1;
               do_fresh  = 1'b1;
            end
         end
         MODE_MINUS: begin
            if (ttl_pkg::is_digit(char_byte)) begin
               mode_mid = MODE_NUMBER;
               dot_mid  = 1'b0;
            end else begin
               tok[n[0]] = ttl_pkg::make_tok(ttl_pkg::KIND_SYMBOL, start_ff,
                                             ttl_pkg::pos_inc(start_ff), ttl_pkg::CHR_MINUS,
                                             1'b0);
               n         = n + 2'd1;
               do_fresh  = 1'b1;
            end
         end
         default: begin
            do_fresh = 1'b1;
         end
      endcase

      // byte lexed from idle
      if (do_fresh) begin
         mode_mid = MODE_IDLE;
         if (ttl_pkg::is_space(char_byte)) begin
            mode_mid = MODE_IDLE;
         end else if (char_byte == ttl_pkg::CHR_QUOTE) begin
            mode_mid  = MODE_STRING;
            start_mid = p;
         end else if (ttl_pkg::is_digit(char_byte)) begin
            mode_mid  = MODE_NUMBER;
            start_mid = p;
            dot_mid   = 1'b0;
         end else if (char_byte == ttl_pkg::CHR_MINUS) begin
            mode_mid  = MODE_MINUS;
            start_mid = p;
         end else if (ttl_pkg::is_symbol(char_byte)) begin
            tok[n[0]] = ttl_pkg::make_tok(ttl_pkg::KIND_SYMBOL, p, p1, char_byte, 1'b0);
            n         = n + 2'd1;
         end else if (ttl_pkg::is_alpha(char_byte) || char_byte == ttl_pkg::CHR_UNDERSCORE) begin
            mode_mid  = MODE_IDENT;
            start_mid = p;
         end else begin
            tok[n[0]] = ttl_pkg::make_tok(ttl_pkg::KIND_UNKNOWN, p, p1, char_byte, 1'b0);
            n         = n + 2'd1;
         end
      end

      mode_in  = mode_mid;
      start_in = start_mid;
      dot_in   = dot_mid;
      pos_in   = p1;

      // buffer end flushes the open token
      if (last_char) begin
         unique case (mode_mid)
            MODE_NUMBER: begin
               tok[n[0]] = ttl_pkg::make_tok(dot_mid ? ttl_pkg::KIND_FLOAT : ttl_pkg::KIND_INT,
                                             start_mid, p1, 8'd0, 1'b0);
               n         = n + 2'd1;
            end
            MODE_IDENT: begin
               tok[n[0]] = ttl_pkg::make_tok(ttl_pkg::KIND_IDENT, start_mid, p1, 8'd0, 1'b0);
               n         = n + 2'd1;
            end
            MODE_MINUS: begin
               tok[n[0]] = ttl_pkg::make_tok(ttl_pkg::KIND_SYMBOL, start_mid,
                                             ttl_pkg::pos_inc(start_mid), ttl_pkg::CHR_MINUS,
                                             1'b0);
               n         = n + 2'd1;
            end
            MODE_STRING: begin
               tok[n[0]] = ttl_pkg::make_tok(ttl_pkg::KIND_STRING, start_mid, p1, 8'd0, 1'b1);
               n         = n + 2'd1;
            end
            default: begin
               n = n;
            end
         endcase
         mode_in  = MODE_IDLE;
         start_in = '0;
         dot_in   = 1'b0;
         pos_in   = '0;
      end

      tok[0].run_last = (n == 2'd1);
      tok[1].run_last = 1'b1;

      scan_out.count = fire ? n : 2'd0;
      scan_out.tok0  = tok[0];
      scan_out.tok1  = tok[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         dot_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         dot_ff   <= dot_in;
      end
   end

endmodule

@@ rtl/core/ttl_result_fifo.sv @@
// ---------------------------------------------------------------------------
// ttl_result_fifo
// Small token queue, takes up to two tokens a cycle and gives one
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ttl_result_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         push_n,
   input  ttl_pkg::token_type tok0,
   input  ttl_pkg::token_type tok1,
   input  logic               pop,
   output ttl_pkg::token_type head,
   output logic               head_valid,
   output logic               room
);

   ttl_pkg::token_type mem_ff [ttl_pkg::RES_DEPTH];
   ttl_pkg::ptr_type   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   ttl_pkg::cnt_type   count_ff, count_in;
   ttl_pkg::ptr_type   wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + ttl_pkg::ptr_type'(1);
   assign wr_ptr_in   = wr_ptr_ff + ttl_pkg::ptr_type'(push_n);
   assign rd_ptr_in   = rd_ptr_ff + ttl_pkg::ptr_type'(pop);
   assign count_in    = count_ff + ttl_pkg::cnt_type'(push_n) - ttl_pkg::cnt_type'(pop);

   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign room       = (count_ff <= ttl_pkg::cnt_type'(ttl_pkg::RES_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= tok0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_next] <= tok1;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= ttl_pkg::cnt_type'(ttl_pkg::RES_DEPTH), "token queue overflow")
   `ASSERT_IMPLIES(a_push_room, clock, reset, push_n != 2'd0, room, "tokens pushed without room")
   `ASSERT_NEXT(a_pop_drain, clock, reset, pop && push_n == 2'd0, count_ff == $past(count_ff) - ttl_pkg::cnt_type'(1), "queue level wrong after pop")

endmodule

@@ rtl/core/text_token_lexer.sv @@
// an accepted item waits in the input stage register until the token queue has room, then its tokens are queued
// throughput: one byte per cycle while the token queue has room for two tokens
// each token leaves at one per cycle while rsp_stall is low, so bytes that close two tokens slow the input
// the lexer state register updates once per byte and bounds the rate
// reset (synchronous): mode idle, offsets zero, input stage and token queue empty
// ---------------------------------------------------------------------------
// text_token_lexer
// Streaming lexer: one text byte per item in, tokens with kind and offsets out
// ---------------------------------------------------------------------------
module text_token_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_last_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_end,
   output logic [7:0]  rsp_symbol_char,
   output logic        rsp_unterminated,
   output logic        rsp_run_last
);

   logic                  s1_valid_ff, s1_valid_in;
   logic [7:0]            s1_byte_ff;
   logic                  s1_last_ff;
   logic                  s1_fire;
   logic                  room;
   logic                  req_take;
   logic                  pop;
   ttl_pkg::scan_out_type scan_out;
   ttl_pkg::token_type    head;

   assign s1_fire   = s1_valid_ff && room;
   assign req_stall = s1_valid_ff && !room;
   assign req_take  = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_char_byte;
         s1_last_ff <= req_last_char;
      end
   end

   ttl_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .fire      (s1_fire),
      .char_byte (s1_byte_ff),
      .last_char (s1_last_ff),
      .scan_out  (scan_out)
   );

   ttl_result_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_n     (scan_out.count),
      .tok0       (scan_out.tok0),
      .tok1       (scan_out.tok1),
      .pop        (pop),
      .head       (head),
      .head_valid (rsp_valid),
      .room       (room)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start_off;
   assign rsp_token_end    = head.end_off;
   assign rsp_symbol_char  = head.sym;
   assign rsp_unterminated = head.unterm;
   assign rsp_run_last     = head.run_last;

endmodule

@@ dv/tb_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_checker
// Watches both channels of the lexer, works out the tokens each accepted byte
// should give and compares every token that leaves with the oldest one due
// ---------------------------------------------------------------------------
module tb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_last_char,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_token_kind,
   input  logic [15:0] rsp_token_start,
   input  logic [15:0] rsp_token_end,
   input  logic [7:0]  rsp_symbol_char,
   input  logic        rsp_unterminated,
   input  logic        rsp_run_last,
   output int          error_count,
   output int          tokens_pending
);

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_STRING,
      SCAN_NUMBER,
      SCAN_IDENT,
      SCAN_MINUS
   } scan_mode_type;

   scan_mode_type      scan_mode;
   ttl_pkg::pos_type   next_pos;
   ttl_pkg::pos_type   token_origin;
   logic               seen_dot;
   ttl_pkg::token_type expected_tokens[$];
   ttl_pkg::token_type step_tokens[$];

   string      punct_set = ".,:;#(){}[]+-*/%&|^<>!$=?";

   function automatic logic blank_char(input logic [7:0] c);
      return c inside {8'h20, 8'h09, 8'h0D, 8'h0A, ttl_pkg::CHR_BACKSPACE};
   endfunction

   function automatic logic digit_char(input logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic logic letter_char(input logic [7:0] c);
      return c inside {["a":"z"], ["A":"Z"]};
   endfunction

   function automatic logic punct_char(input logic [7:0] c);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < punct_set.len(); i++)
         if (punct_set[i] == c) hit = 1'b1;
      return hit;
   endfunction

   function automatic logic word_char(input logic [7:0] c);
      return letter_char(c) || digit_char(c) || c == ttl_pkg::CHR_UNDERSCORE;
   endfunction

   function automatic logic numeral_char(input logic [7:0] c);
      logic [7:0] folded;
      folded = c inside {["A":"Z"]} ? c + 8'd32 : c;
      return digit_char(folded) || folded inside {["a":"f"], "x", "o", "u", "l"} ||
             folded == ttl_pkg::CHR_MINUS || folded == ttl_pkg::CHR_UNDERSCORE ||
             folded == ttl_pkg::CHR_DOT;
   endfunction

   function automatic ttl_pkg::pos_type pos_step(input ttl_pkg::pos_type p);
      return (&p) ? p : p + 1'b1;
   endfunction

   task automatic add_token(input logic [2:0] kind, input ttl_pkg::pos_type first_p,
                            input ttl_pkg::pos_type stop_p, input logic [7:0] sym,
                            input logic unterm);
      ttl_pkg::token_type t;
      t.kind      = kind;
      t.start_off = ttl_pkg::off_type'(first_p);
      t.end_off   = ttl_pkg::off_type'(stop_p);
      t.sym       = sym;
      t.unterm    = unterm;
      t.run_last  = 1'b0;
      step_tokens.push_back(t);
   endtask

   // byte seen from the idle mode
   task automatic scan_fresh(input logic [7:0] c, input ttl_pkg::pos_type p);
      scan_mode = SCAN_IDLE;
      if (blank_char(c)) begin
      end else if (c == ttl_pkg::CHR_QUOTE) begin
         scan_mode    = SCAN_STRING;
         token_origin = p;
      end else if (digit_char(c)) begin
         scan_mode    = SCAN_NUMBER;
         token_origin = p;
         seen_dot     = 1'b0;
      end else if (c == ttl_pkg::CHR_MINUS) begin
         scan_mode    = SCAN_MINUS;
         token_origin = p;
      end else if (punct_char(c)) begin
         add_token(ttl_pkg::KIND_SYMBOL, p, pos_step(p), c, 1'b0);
      end else if (letter_char(c) || c == ttl_pkg::CHR_UNDERSCORE) begin
         scan_mode    = SCAN_IDENT;
         token_origin = p;
      end else begin
         add_token(ttl_pkg::KIND_UNKNOWN, p, pos_step(p), c, 1'b0);
      end
   endtask

   task automatic predict_tokens(input logic [7:0] c, input logic last);
      ttl_pkg::pos_type p;
      ttl_pkg::pos_type p1;
      p  = next_pos;
      p1 = pos_step(p);
      step_tokens.delete();
      case (scan_mode)
         SCAN_STRING: begin
            if (c == ttl_pkg::CHR_QUOTE) begin
               add_token(ttl_pkg::KIND_STRING, token_origin, p1, 8'h00, 1'b0);
               scan_mode = SCAN_IDLE;
            end
         end
         SCAN_NUMBER: begin
            if (numeral_char(c)) begin
               if (c == ttl_pkg::CHR_DOT) seen_dot = 1'b1;
            end else begin
               add_token(seen_dot ? ttl_pkg::KIND_FLOAT : ttl_pkg::KIND_INT, token_origin, p,
                         8'h00, 1'b0);
               scan_fresh(c, p);
            end
         end
         SCAN_IDENT: begin
            if (!word_char(c)) begin
               add_token(ttl_pkg::KIND_IDENT, token_origin, p, 8'h00, 1'b0);
               scan_fresh(c, p);
            end
         end
         SCAN_MINUS: begin
            if (digit_char(c)) begin
               scan_mode = SCAN_NUMBER;
               seen_dot  = 1'b0;
            end else begin
               add_token(ttl_pkg::KIND_SYMBOL, token_origin, pos_step(token_origin),
                         ttl_pkg::CHR_MINUS, 1'b0);
               scan_fresh(c, p);
            end
         end
         default: scan_fresh(c, p);
      endcase

      if (last) begin
         case (scan_mode)
            SCAN_NUMBER:
               add_token(seen_dot ? ttl_pkg::KIND_FLOAT : ttl_pkg::KIND_INT, token_origin, p1,
                         8'h00, 1'b0);
            SCAN_IDENT:
               add_token(ttl_pkg::KIND_IDENT, token_origin, p1, 8'h00, 1'b0);
            SCAN_MINUS:
               add_token(ttl_pkg::KIND_SYMBOL, token_origin, pos_step(token_origin),
                         ttl_pkg::CHR_MINUS, 1'b0);
            SCAN_STRING:
               add_token(ttl_pkg::KIND_STRING, token_origin, p1, 8'h00, 1'b1);
            default: ;
         endcase
         scan_mode    = SCAN_IDLE;
         next_pos     = '0;
         token_origin = '0;
         seen_dot     = 1'b0;
      end else begin
         next_pos = p1;
      end

      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].run_last = 1'b1;
      foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      ttl_pkg::token_type want;
      if (reset) begin
         scan_mode    = SCAN_IDLE;
         next_pos     = '0;
         token_origin = '0;
         seen_dot     = 1'b0;
         expected_tokens.delete();
      end else begin
         if (req_valid && !req_stall) predict_tokens(req_char_byte, req_last_char);
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               $error("token with none due: kind %0d start %0d end %0d",
                      rsp_token_kind, rsp_token_start, rsp_token_end);
               error_count++;
            end else begin
               want = expected_tokens.pop_front();
               check_field("token_kind", want.kind, rsp_token_kind);
               check_field("token_start", want.start_off, rsp_token_start);
               check_field("token_end", want.end_off, rsp_token_end);
               check_field("symbol_char", want.sym, rsp_symbol_char);
               check_field("unterminated", want.unterm, rsp_unterminated);
               check_field("run_last", want.run_last, rsp_run_last);
            end
         end
      end
      tokens_pending = expected_tokens.size();
   end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Feeds the lexer with directed and random text buffers, with idling on both
// sides in the first two phases, and gives the verdict from the checker's error count and pending tokens
// ---------------------------------------------------------------------------
module tb_top;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_ITEMS  = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_byte = 8'h00;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_end;
   logic [7:0]  rsp_symbol_char;
   logic        rsp_unterminated;
   logic        rsp_run_last;

   int          error_count;
   int          tokens_pending;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          phase_items;

   logic [7:0]  text_bytes[$];
   logic [7:0]  blank_set[5] = '{8'h20, 8'h09, 8'h0D, 8'h0A, ttl_pkg::CHR_BACKSPACE};
   string       word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string       numeral_chars = "0123456789abcdefABCDEFxXoOuUlL-_.";
   string       punct_set = ".,:;#(){}[]+-*/%&|^<>!$=?";

   always #5 clock = ~clock;

   text_token_lexer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_end    (rsp_token_end),
      .rsp_symbol_char  (rsp_symbol_char),
      .rsp_unterminated (rsp_unterminated),
      .rsp_run_last     (rsp_run_last)
   );

   tb_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_byte    (req_char_byte),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_end    (rsp_token_end),
      .rsp_symbol_char  (rsp_symbol_char),
      .rsp_unterminated (rsp_unterminated),
      .rsp_run_last     (rsp_run_last),
      .error_count      (error_count),
      .tokens_pending   (tokens_pending)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_byte <= c;
      req_last_char <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      phase_items++;
   endtask

   task automatic send_buffer();
      foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
   endtask

   task automatic add_numeral_tail();
      repeat ($urandom_range(6))
         text_bytes.push_back(numeral_chars[$urandom_range(numeral_chars.len() - 1)]);
   endtask

   task automatic add_piece();
      logic [7:0] c;
      case ($urandom_range(7))
         0: repeat ($urandom_range(1, 3)) text_bytes.push_back(blank_set[$urandom_range(4)]);
         1: begin
            text_bytes.push_back(word_chars[$urandom_range(52)]);
            repeat ($urandom_range(6))
               text_bytes.push_back(word_chars[$urandom_range(word_chars.len() - 1)]);
         end
         2: begin
            text_bytes.push_back(8'd48 + 8'($urandom_range(9)));
            add_numeral_tail();
         end
         3: begin
            text_bytes.push_back(ttl_pkg::CHR_MINUS);
            text_bytes.push_back(8'd48 + 8'($urandom_range(9)));
            add_numeral_tail();
         end
         4: text_bytes.push_back(punct_set[$urandom_range(punct_set.len() - 1)]);
         5: begin
            text_bytes.push_back(ttl_pkg::CHR_QUOTE);
            repeat ($urandom_range(6)) begin
               c = 8'($urandom_range(255));
               text_bytes.push_back(c == ttl_pkg::CHR_QUOTE ? 8'h61 : c);
            end
            if ($urandom_range(3) != 0) text_bytes.push_back(ttl_pkg::CHR_QUOTE);
         end
         6: text_bytes.push_back(8'($urandom_range(255)));
         default: text_bytes.push_back(ttl_pkg::CHR_MINUS);
      endcase
   endtask

   // every item sent so far has given all its tokens
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tokens_pending != 0) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 9;  recv_idle_pct = 74; end
            1: begin send_idle_pct = 74; recv_idle_pct = 9;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         phase_items = 0;

         if (phase == 0) begin
            text_bytes = {ttl_pkg::CHR_QUOTE, "h", "i", ttl_pkg::CHR_QUOTE};
            send_buffer();
            text_bytes = {ttl_pkg::CHR_MINUS, "5", ttl_pkg::CHR_DOT, "e"};
            send_buffer();
            text_bytes = {ttl_pkg::CHR_MINUS, 8'h20, "a"};
            send_buffer();
            text_bytes = {ttl_pkg::CHR_MINUS};
            send_buffer();
            text_bytes = {"1", "2", ";"};
            send_buffer();
            text_bytes = {"z", 8'hFF};
            send_buffer();
            text_bytes = {ttl_pkg::CHR_QUOTE, "a"};
            send_buffer();
            text_bytes = {8'h00, 8'h7F, 8'h80};
            send_buffer();
            text_bytes = {ttl_pkg::CHR_BACKSPACE, 8'h09};
            send_buffer();
            text_bytes = {ttl_pkg::CHR_MINUS, "x"};
            send_buffer();
            drain();
         end

         while (phase_items < PHASE_ITEMS) begin
            text_bytes.delete();
            repeat ($urandom_range(1, 8)) add_piece();
            send_buffer();
         end

         drain();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0 && tokens_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ttl_pkg.sv
rtl/core/ttl_scan.sv
rtl/core/ttl_result_fifo.sv
rtl/core/text_token_lexer.sv
dv/tb_checker.sv
dv/tb_top.sv
